FILE: rtl/epfa_pkg.sv
// epfa_pkg: shared constants and types for the edge period frequency-to-angle block.
// Used by epfa_div and edge_period_frequency_to_angle. No dependencies.
package epfa_pkg;

    // Default timestamp width handed to the top level.
    localparam int TS_BITS = 32;

    // Shared divider sizing: dividend / quotient bits, divisor bits, step counter bits.
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 43;
    localparam int DIV_CW = 6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CENTER_HZ     = 2'd0;
    localparam logic [1:0] CFG_HZ_PER_DEGREE = 2'd1;
    localparam logic [1:0] CFG_ANGLE_SPAN    = 2'd2;
    localparam logic [1:0] CFG_AVG_COUNT     = 2'd3;

    // Register reset values.
    localparam logic [15:0] RST_CENTER_HZ     = 16'd3000;
    localparam logic [9:0]  RST_HZ_PER_DEGREE = 10'd20;
    localparam logic [7:0]  RST_ANGLE_SPAN    = 8'd30;
    localparam logic [15:0] RST_AVG_COUNT     = 16'd1000;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: rtl/edge_period_frequency_to_angle.sv
// edge_period_frequency_to_angle: averaging period meter with angle and PWM duty result.
// Accumulates edge periods; a sequencer drives the shared divider epfa_div. Uses epfa_pkg.
// An edge that does not close a window only adds to the sum and count; one that closes a window
// runs divider passes of 43, 50 and 18 steps (the last is skipped when the duty clamps, all three
// for a zero sum) before its result is loaded. Input is blocked until the result is loaded.
// Reset: synchronous active low; registers return to defaults, sum, count and last edge clear.
module edge_period_frequency_to_angle
    import epfa_pkg::*;
#(
    parameter int P_TS_BITS = TS_BITS
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_edge_time_us,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_freq_q8,
    output logic signed [9:0] o_angle_deg,
    output logic [10:0]       o_pwm_duty,
    output logic              o_zero_period
);

    localparam int LP_TW = (P_TS_BITS < 32) ? P_TS_BITS : 32;

    localparam logic [26:0] FREQ_K   = 27'd128000000;
    localparam logic [18:0] HALF_MHZ = 19'd500000;

    localparam logic [DIV_CW-1:0] STEPS_FQ   = DIV_CW'(43);
    localparam logic [DIV_CW-1:0] STEPS_ANG  = DIV_CW'(50);
    localparam logic [DIV_CW-1:0] STEPS_DUTY = DIV_CW'(18);

    typedef enum logic [3:0] {
        S_IDLE, S_MFQ, S_DFQ, S_WFQ, S_MA, S_MB, S_SUB, S_MC, S_RND,
        S_DANG, S_WANG, S_DUTY, S_DDUT, S_WDUT, S_PUSH
    } t_state;

    t_state r_state;

    logic [15:0]       r_center;
    logic [9:0]        r_hz;
    logic [7:0]        r_span;
    logic [15:0]       r_avg;

    logic [LP_TW-1:0]  r_last;
    logic [31:0]       r_acc;
    logic [15:0]       r_cnt;

    logic [15:0]       r_n;
    logic [31:0]       r_sum;
    logic [DIV_NW-1:0] r_a;
    logic [DIV_NW-1:0] r_b;
    logic              r_neg;
    logic signed [11:0] r_ang;

    logic [31:0]       r_res_freq;
    logic signed [9:0] r_res_angle;
    logic [10:0]       r_res_duty;
    logic              r_res_zero;

    logic              r_o_valid;
    logic [31:0]       r_o_freq;
    logic signed [9:0] r_o_angle;
    logic [10:0]       r_o_duty;
    logic              r_o_zero;

    logic [LP_TW-1:0]  w_diff;
    logic [31:0]       w_sum;
    logic [15:0]       w_cnt;
    logic              w_emit;
    logic              w_in_acc;
    logic [9:0]        w_hz_eff;
    logic [7:0]        w_span_eff;
    logic signed [11:0] w_span_s;
    logic signed [11:0] w_ang_sum;
    logic [9:0]        w_mag;
    logic [DIV_NW:0]   w_sub;

    t_div_ctl          w_div_ctl;
    t_div_sts          w_div_sts;
    logic [DIV_NW-1:0] w_quo;

    assign w_diff     = i_edge_time_us[LP_TW-1:0] - r_last;
    assign w_sum      = r_acc + 32'(w_diff);
    assign w_cnt      = r_cnt + 16'd1;
    assign w_emit     = w_cnt >= r_avg;
    assign w_in_acc   = i_valid && o_ready;
    assign w_hz_eff   = (r_hz == '0) ? 10'd1 : r_hz;
    assign w_span_eff = (r_span == '0) ? 8'd1 : r_span;
    assign w_span_s   = $signed({4'b0, w_span_eff});
    assign w_ang_sum  = r_ang + w_span_s;
    assign w_mag      = (|w_quo[DIV_NW-1:10]) ? 10'd1023 : w_quo[9:0];
    assign w_sub      = {1'b0, r_a} - {1'b0, r_b};

    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = STEPS_FQ;
        case (r_state)
            S_DFQ: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = STEPS_FQ;
            end
            S_DANG: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = STEPS_ANG;
            end
            S_DDUT: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = STEPS_DUTY;
            end
            default: begin
                w_div_ctl.start = 1'b0;
            end
        endcase
    end

    epfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_a),
        .i_den   (r_b[DIV_DW-1:0]),
        .o_sts   (w_div_sts),
        .o_quo   (w_quo)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= RST_CENTER_HZ;
            r_hz     <= RST_HZ_PER_DEGREE;
            r_span   <= RST_ANGLE_SPAN;
            r_avg    <= RST_AVG_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_HZ:     r_center <= i_cfg_data;
                CFG_HZ_PER_DEGREE: r_hz     <= i_cfg_data[9:0];
                CFG_ANGLE_SPAN:    r_span   <= i_cfg_data[7:0];
                CFG_AVG_COUNT:     r_avg    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && r_state != S_PUSH) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_last <= i_edge_time_us[LP_TW-1:0];
                        if (w_emit) begin
                            r_acc <= '0;
                            r_cnt <= '0;
                            r_n   <= w_cnt;
                            r_sum <= w_sum;
                            if (w_sum == '0) begin
                                r_res_zero  <= 1'b1;
                                r_res_freq  <= '0;
                                r_res_angle <= '0;
                                r_res_duty  <= '0;
                                r_state     <= S_PUSH;
                            end else begin
                                r_res_zero <= 1'b0;
                                r_state    <= S_MFQ;
                            end
                        end else begin
                            r_acc <= w_sum;
                            r_cnt <= w_cnt;
                        end
                    end
                end
                S_MFQ: begin
                    r_a     <= {43'(FREQ_K) * 43'(r_n), 7'b0};
                    r_b     <= DIV_NW'(r_sum);
                    r_state <= S_DFQ;
                end
                S_DFQ: begin
                    r_state <= S_WFQ;
                end
                S_WFQ: begin
                    if (w_div_sts.done) begin
                        r_res_freq <= (|w_quo[DIV_NW-1:32]) ? 32'hFFFF_FFFF : w_quo[31:0];
                        r_state    <= S_MA;
                    end
                end
                S_MA: begin
                    r_a     <= DIV_NW'(HALF_MHZ) * DIV_NW'(r_n);
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_b     <= DIV_NW'(r_center) * DIV_NW'(r_sum);
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    // magnitude and sign of the frequency offset numerator
                    r_neg   <= w_sub[DIV_NW];
                    r_a     <= w_sub[DIV_NW] ? (r_b - r_a) : w_sub[DIV_NW-1:0];
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_b     <= DIV_NW'(w_hz_eff) * DIV_NW'(r_sum);
                    r_state <= S_RND;
                end
                S_RND: begin
                    // round half away: (2|num| + den) / (2 den)
                    r_a     <= {r_a[DIV_NW-2:0], 1'b0} + r_b;
                    r_b     <= {r_b[DIV_NW-2:0], 1'b0};
                    r_state <= S_DANG;
                end
                S_DANG: begin
                    r_state <= S_WANG;
                end
                S_WANG: begin
                    if (w_div_sts.done) begin
                        r_ang   <= r_neg ? -$signed({2'b0, w_mag}) : $signed({2'b0, w_mag});
                        r_state <= S_DUTY;
                    end
                end
                S_DUTY: begin
                    if (r_ang > 12'sd511) begin
                        r_res_angle <= 10'sd511;
                    end else if (r_ang < -12'sd512) begin
                        r_res_angle <= -10'sd512;
                    end else begin
                        r_res_angle <= r_ang[9:0];
                    end
                    if (r_ang >= w_span_s) begin
                        r_res_duty <= 11'd1024;
                        r_state    <= S_PUSH;
                    end else if (w_ang_sum < 12'sd0) begin
                        r_res_duty <= '0;
                        r_state    <= S_PUSH;
                    end else begin
                        r_a     <= {w_ang_sum[8:0], 9'b0, 32'b0};
                        r_b     <= DIV_NW'(w_span_eff);
                        r_state <= S_DDUT;
                    end
                end
                S_DDUT: begin
                    r_state <= S_WDUT;
                end
                S_WDUT: begin
                    if (w_div_sts.done) begin
                        r_res_duty <= w_quo[10:0];
                        r_state    <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_freq  <= r_res_freq;
                        r_o_angle <= r_res_angle;
                        r_o_duty  <= r_res_duty;
                        r_o_zero  <= r_res_zero;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_freq_q8     = r_o_freq;
    assign o_angle_deg   = r_o_angle;
    assign o_pwm_duty    = r_o_duty;
    assign o_zero_period = r_o_zero;

endmodule

FILE: rtl/epfa_div.sv
// epfa_div: iterative restoring divider, one quotient bit per cycle.
// Processes the top 'steps' bits of a left-aligned dividend. Depends on epfa_pkg.
module epfa_div
    import epfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output t_div_sts          o_sts,
    output logic [DIV_NW-1:0] o_quo
);

    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= i_ctl.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[DIV_NW-2:0], 1'b0};
                r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

FILE: tb/edge_period_frequency_to_angle_tb.sv
// edge_period_frequency_to_angle_tb: self-checking bench for the averaging period meter.
// A scoreboard class predicts every reading from the accepted edges; tasks drive edges,
// settings and back-pressure. Depends on epfa_pkg and edge_period_frequency_to_angle.
module edge_period_frequency_to_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import epfa_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [31:0]        freq_q8;
        logic signed [9:0]  angle_deg;
        logic [10:0]        pwm_duty;
        logic               zero_period;
    } reading_t;

    class freq_angle_scoreboard;
        logic [15:0] center_hz;
        logic [9:0]  hz_per_degree;
        logic [7:0]  angle_span;
        logic [15:0] avg_count;
        logic [31:0] last_edge;
        logic [31:0] period_sum;
        logic [15:0] edge_count;
        reading_t    expected_readings[$];
        int          mismatch_count;

        function new();
            center_hz      = RST_CENTER_HZ;
            hz_per_degree  = RST_HZ_PER_DEGREE;
            angle_span     = RST_ANGLE_SPAN;
            avg_count      = RST_AVG_COUNT;
            last_edge      = '0;
            period_sum     = '0;
            edge_count     = '0;
            mismatch_count = 0;
        endfunction

        function void set_config(logic [15:0] center, logic [9:0] hz_deg, logic [7:0] span,
                                 logic [15:0] avg);
            center_hz     = center;
            hz_per_degree = hz_deg;
            angle_span    = span;
            avg_count     = avg;
        endfunction

        function reading_t compute_reading(longint unsigned n, longint unsigned sum);
            reading_t        r;
            longint unsigned fq, hz, mag, q;
            longint          num, den, ang, span, t, duty;
            r = '0;
            if (sum == 0) begin
                r.zero_period = 1'b1;
                return r;
            end
            fq = (64'd128000000 * n) / sum;
            if (fq > 64'hFFFF_FFFF)
                fq = 64'hFFFF_FFFF;
            hz   = (hz_per_degree == 0) ? 1 : hz_per_degree;
            num  = longint'(64'd500000 * n) - longint'(center_hz * sum);
            den  = longint'(hz * sum);
            // half away from zero
            mag  = (num < 0) ? -num : num;
            q    = (2 * mag + den) / (2 * den);
            ang  = (num < 0) ? -longint'(q) : longint'(q);
            span = (angle_span == 0) ? 1 : angle_span;
            t    = (ang + span) * 1024;
            if (t < 0) begin
                duty = 0;
            end else begin
                duty = t / (2 * span);
                if (duty > 1024)
                    duty = 1024;
            end
            if (ang > 511)
                r.angle_deg = 10'h1FF;
            else if (ang < -512)
                r.angle_deg = 10'h200;
            else
                r.angle_deg = ang[9:0];
            r.freq_q8  = fq[31:0];
            r.pwm_duty = duty[10:0];
            return r;
        endfunction

        function void note_edge(logic [31:0] edge_time);
            period_sum = period_sum + (edge_time - last_edge);
            last_edge  = edge_time;
            edge_count = edge_count + 16'd1;
            if (edge_count >= avg_count) begin
                expected_readings.push_back(compute_reading(edge_count, period_sum));
                period_sum = '0;
                edge_count = '0;
            end
        endfunction

        function void compare_field(string field, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [31:0] freq, logic signed [9:0] angle,
                                   logic [10:0] duty, logic zero);
            reading_t want;
            if (expected_readings.size() == 0) begin
                $display("%0t: reading with nothing expected: freq_q8 %0d angle_deg %0d %s %0d %0d",
                         $time, freq, angle, "pwm_duty/zero_period", duty, zero);
                mismatch_count++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("freq_q8", want.freq_q8, freq);
            compare_field("angle_deg", want.angle_deg, angle);
            compare_field("pwm_duty", want.pwm_duty, duty);
            compare_field("zero_period", want.zero_period, zero);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [1:0]        i_cfg_idx      = CFG_CENTER_HZ;
    logic [15:0]       i_cfg_data     = '0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    logic [31:0]       i_edge_time_us = '0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    logic [31:0]       o_freq_q8;
    logic signed [9:0] o_angle_deg;
    logic [10:0]       o_pwm_duty;
    logic              o_zero_period;

    freq_angle_scoreboard scoreboard = new();
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int unsigned          quiet_cycles  = 0;

    edge_period_frequency_to_angle DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_edge_time_us (i_edge_time_us),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_freq_q8      (o_freq_q8),
        .o_angle_deg    (o_angle_deg),
        .o_pwm_duty     (o_pwm_duty),
        .o_zero_period  (o_zero_period)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            scoreboard.check_result(o_freq_q8, o_angle_deg, o_pwm_duty, o_zero_period);
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic send_edge(input logic [31:0] edge_time);
        int gap;
        i_valid        <= 1'b1;
        i_edge_time_us <= edge_time;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        scoreboard.note_edge(edge_time);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_readings_drained();
        if (scoreboard.expected_readings.size() != 0) begin
            i_valid <= 1'b0;
            while (scoreboard.expected_readings.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic write_settings(input logic [15:0] center, input logic [9:0] hz_deg,
                                  input logic [7:0] span, input logic [15:0] avg);
        wait_readings_drained();
        i_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CENTER_HZ;
        i_cfg_data <= center;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HZ_PER_DEGREE;
        i_cfg_data <= {6'd0, hz_deg};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ANGLE_SPAN;
        i_cfg_data <= {8'd0, span};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AVG_COUNT;
        i_cfg_data <= avg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.set_config(center, hz_deg, span, avg);
    endtask

    // Mostly a typical value in [lo, typ_hi], now and then one of the extremes.
    function automatic int unsigned pick_setting(int unsigned lo, int unsigned typ_hi,
                                                 int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return lo;
        if (roll < 16)
            return hi;
        return $urandom_range(lo, typ_hi);
    endfunction

    // Half period for a frequency a random angle away from center.
    function automatic logic [31:0] steady_period();
        longint          eff_hz, eff_span, angle, target;
        longint unsigned half;
        eff_hz   = (scoreboard.hz_per_degree == 0) ? 1 : scoreboard.hz_per_degree;
        eff_span = (scoreboard.angle_span == 0) ? 1 : scoreboard.angle_span;
        angle    = longint'($urandom_range(0, 2 * eff_span + 16)) - eff_span - 8;
        target   = longint'(scoreboard.center_hz) + eff_hz * angle;
        if (target < 10)
            target = $urandom_range(10, 100);
        half = 500000 / target;
        if (half == 0)
            half = 1;
        return 32'(half - half / 64 + $urandom_range(0, half / 32));
    endfunction

    function automatic logic [31:0] next_edge_time(logic [31:0] prev, int burst_pct);
        int roll;
        if ($urandom_range(99) < burst_pct)
            return prev + (($urandom_range(63) == 0) ? 32'd1 : 32'd0);
        roll = $urandom_range(99);
        if (roll < 8)
            return $urandom();
        if (roll < 14)
            return prev + $urandom();
        return prev + steady_period();
    endfunction

    initial begin
        logic [31:0] edge_time;
        int          burst_pct;
        int          item_total;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(23, 62);
        write_settings(RST_CENTER_HZ, RST_HZ_PER_DEGREE, RST_ANGLE_SPAN, 16'd1);
        send_edge(32'd0);           // zero sum: first edge at time zero
        send_edge(32'd167);
        send_edge(32'hFFFF_FFFF);
        send_edge(32'd5);           // timestamp wraps
        send_edge(32'd6);           // 1 us period, angle saturates high
        write_settings(16'd4999, 10'd2, 8'd30, 16'd1);
        send_edge(32'd106);         // +0.5 degree
        write_settings(16'd5001, 10'd2, 8'd30, 16'd1);
        send_edge(32'd206);         // -0.5 degree
        write_settings(RST_CENTER_HZ, 10'd0, 8'd0, 16'd0);
        send_edge(32'd372);
        send_edge(32'd538);
        send_edge(32'd538);
        write_settings(16'hFFFF, 10'd1, 8'd180, 16'd1);
        send_edge(32'd100538);      // far below center, saturates low
        write_settings(16'd0, 10'd1023, 8'd1, 16'hFFFF);
        send_edge(32'd100539);
        send_edge(32'd100540);
        send_edge(32'd100541);
        write_settings(16'd0, 10'd1023, 8'd1, 16'd2);  // count already past the window
        send_edge(32'd100543);

        edge_time = 32'd100543;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 4)
                set_idling(62, 23);
            else if (phase == 8)
                set_idling(0, 0);
            // phase 2: mostly repeated timestamps over long windows
            write_settings(16'(pick_setting(0, 20000, 65535)), 10'(pick_setting(0, 100, 1023)),
                           8'(pick_setting(0, 180, 255)),
                           (phase == 2) ? 16'd40 : 16'(pick_setting(0, 16, 64)));
            burst_pct  = (phase == 2) ? 100 : 5;
            item_total = $urandom_range(70, 100);
            for (int k = 0; k < item_total; k++) begin
                if ($urandom_range(49) == 0)
                    wait_readings_drained();
                edge_time = next_edge_time(edge_time, burst_pct);
                send_edge(edge_time);
            end
        end

        wait_readings_drained();
        i_valid <= 1'b0;
        repeat (150) @(posedge i_clk);
        if (scoreboard.mismatch_count == 0 && scoreboard.expected_readings.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/epfa_pkg.sv
rtl/epfa_div.sv
rtl/edge_period_frequency_to_angle.sv
tb/edge_period_frequency_to_angle_tb.sv
